### rtl/core/f2sb_pkg.sv
// Shared widths, event codes and bridge phase codes for the fabric to system bus bridge.
`default_nettype none

package f2sb_pkg;

    localparam int ADDR_BITS_DEF = 24;
    localparam int REQ_W         = 3;
    localparam int DATA_W        = 8;
    localparam int PHASE_W       = 3;

    // Event codes carried in req_type.
    localparam logic [REQ_W-1:0] REQ_CYC_START = 3'd0;
    localparam logic [REQ_W-1:0] REQ_CYC_END   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ADDR      = 3'd2;
    localparam logic [REQ_W-1:0] REQ_WDATA     = 3'd3;
    localparam logic [REQ_W-1:0] REQ_TICK      = 3'd4;
    localparam logic [REQ_W-1:0] REQ_TOCK      = 3'd5;

    // Bridge phases.
    localparam logic [PHASE_W-1:0] PH_IDLE      = 3'd0;
    localparam logic [PHASE_W-1:0] PH_READ      = 3'd1;
    localparam logic [PHASE_W-1:0] PH_WRITE     = 3'd2;
    localparam logic [PHASE_W-1:0] PH_WRITE_DAT = 3'd3;
    localparam logic [PHASE_W-1:0] PH_WAIT_TICK = 3'd4;

    typedef logic [DATA_W-1:0] t_byte;

endpackage

`default_nettype wire

### rtl/core/f2sb_if.sv
// Valid/ready channel interfaces for bridge event words and result words.
`default_nettype none

interface f2sb_req_if #(
    parameter int ADDR_BITS = f2sb_pkg::ADDR_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [f2sb_pkg::REQ_W-1:0]   req_type;
    logic [ADDR_BITS-1:0]         addr_in;
    logic                         write_en;
    logic [f2sb_pkg::DATA_W-1:0]  wdata_in;
    logic                         sys_phase;
    logic [f2sb_pkg::DATA_W-1:0]  bus_rdata;

    modport source (
        output valid, req_type, addr_in, write_en, wdata_in, sys_phase, bus_rdata,
        input  ready
    );
    modport sink (
        input  valid, req_type, addr_in, write_en, wdata_in, sys_phase, bus_rdata,
        output ready
    );
endinterface

interface f2sb_rsp_if #(
    parameter int ADDR_BITS = f2sb_pkg::ADDR_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         ack_out;
    logic                         rdata_valid;
    logic [f2sb_pkg::DATA_W-1:0]  rdata_out;
    logic                         bus_start;
    logic [ADDR_BITS-1:0]         bus_addr;
    logic                         bus_read;
    logic                         bus_wdata_valid;
    logic [f2sb_pkg::DATA_W-1:0]  bus_wdata;

    modport source (
        output valid, ack_out, rdata_valid, rdata_out, bus_start, bus_addr, bus_read,
               bus_wdata_valid, bus_wdata,
        input  ready
    );
    modport sink (
        input  valid, ack_out, rdata_valid, rdata_out, bus_start, bus_addr, bus_read,
               bus_wdata_valid, bus_wdata,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/f2sb_core.sv
// Input register, bridge state and the per-word decode that forms one result word.
`default_nettype none

module f2sb_core #(
    parameter int ADDR_BITS = f2sb_pkg::ADDR_BITS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    f2sb_req_if.sink     i_req,
    f2sb_rsp_if.source   o_res
);
    import f2sb_pkg::*;

    // Input register.
    logic                 r_in_valid;
    logic [REQ_W-1:0]     r_req_type;
    logic [ADDR_BITS-1:0] r_addr_in;
    logic                 r_write_en;
    t_byte                r_wdata_in;
    logic                 r_sys_phase;
    t_byte                r_bus_rdata;

    // Bridge state.
    logic [PHASE_W-1:0]   r_phase, n_phase;
    logic                 r_cycle_pending, n_cycle_pending;
    logic                 r_wdata_pending, n_wdata_pending;
    logic [ADDR_BITS-1:0] r_latched_addr, n_latched_addr;
    logic                 r_latched_write, n_latched_write;
    t_byte                r_latched_wdata, n_latched_wdata;
    logic                 r_tock_flag, n_tock_flag;
    logic                 r_tock_flag_dly, n_tock_flag_dly;

    logic                 advance;

    assign advance     = r_in_valid && o_res.ready;
    assign i_req.ready = !r_in_valid || o_res.ready;
    assign o_res.valid = r_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req_type  <= i_req.req_type;
            r_addr_in   <= i_req.addr_in;
            r_write_en  <= i_req.write_en;
            r_wdata_in  <= i_req.wdata_in;
            r_sys_phase <= i_req.sys_phase;
            r_bus_rdata <= i_req.bus_rdata;
        end
    end

    always_comb begin
        n_phase         = r_phase;
        n_cycle_pending = r_cycle_pending;
        n_wdata_pending = r_wdata_pending;
        n_latched_addr  = r_latched_addr;
        n_latched_write = r_latched_write;
        n_latched_wdata = r_latched_wdata;
        n_tock_flag     = r_tock_flag;
        n_tock_flag_dly = r_tock_flag_dly;

        o_res.ack_out         = 1'b0;
        o_res.rdata_valid     = 1'b0;
        o_res.rdata_out       = '0;
        o_res.bus_start       = 1'b0;
        o_res.bus_addr        = '0;
        o_res.bus_read        = 1'b0;
        o_res.bus_wdata_valid = 1'b0;
        o_res.bus_wdata       = '0;

        unique case (r_req_type)
            REQ_CYC_START: begin
                n_cycle_pending = 1'b1;
            end
            REQ_CYC_END: begin
                if (r_phase == PH_READ) begin
                    n_phase = PH_IDLE;
                end else if (r_phase == PH_WRITE || r_phase == PH_WRITE_DAT) begin
                    n_phase = PH_WAIT_TICK;
                end
                n_cycle_pending = 1'b0;
                n_wdata_pending = 1'b0;
            end
            REQ_ADDR: begin
                n_latched_addr  = r_addr_in;
                n_latched_write = r_write_en;
            end
            REQ_WDATA: begin
                n_latched_wdata = r_wdata_in;
                n_wdata_pending = 1'b1;
                if (r_phase == PH_WRITE) begin
                    o_res.bus_wdata_valid = 1'b1;
                    o_res.bus_wdata       = r_wdata_in;
                    o_res.ack_out         = 1'b1;
                    n_phase               = PH_WRITE_DAT;
                end
            end
            REQ_TICK: begin
                if (r_sys_phase) begin
                    if (r_phase == PH_READ) begin
                        o_res.rdata_valid = 1'b1;
                        o_res.rdata_out   = r_bus_rdata;
                        o_res.ack_out     = 1'b1;
                        n_phase           = PH_IDLE;
                    end else if (r_phase == PH_WAIT_TICK) begin
                        n_phase = PH_IDLE;
                    end
                end
                n_tock_flag = r_sys_phase;
            end
            REQ_TOCK: begin
                if (r_tock_flag_dly && r_phase == PH_IDLE && r_cycle_pending) begin
                    o_res.bus_start = 1'b1;
                    o_res.bus_addr  = r_latched_addr;
                    o_res.bus_read  = !r_latched_write;
                    if (r_latched_write) begin
                        if (r_wdata_pending) begin
                            o_res.bus_wdata_valid = 1'b1;
                            o_res.bus_wdata       = r_latched_wdata;
                            o_res.ack_out         = 1'b1;
                            n_phase               = PH_WRITE_DAT;
                        end else begin
                            n_phase = PH_WRITE;
                        end
                    end else begin
                        n_phase = PH_READ;
                    end
                end
                n_tock_flag_dly = r_tock_flag;
            end
            default: begin
                // Unused event codes leave the state alone and give an all-zero word.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_cycle_pending <= 1'b0;
            r_wdata_pending <= 1'b0;
            r_latched_addr  <= '0;
            r_latched_write <= 1'b0;
            r_latched_wdata <= '0;
            r_tock_flag     <= 1'b0;
            r_tock_flag_dly <= 1'b0;
        end else if (advance) begin
            r_phase         <= n_phase;
            r_cycle_pending <= n_cycle_pending;
            r_wdata_pending <= n_wdata_pending;
            r_latched_addr  <= n_latched_addr;
            r_latched_write <= n_latched_write;
            r_latched_wdata <= n_latched_wdata;
            r_tock_flag     <= n_tock_flag;
            r_tock_flag_dly <= n_tock_flag_dly;
        end
    end

endmodule

`default_nettype wire

### rtl/core/f2sb_out_stage.sv
// Result register that holds a finished word until the receiver takes it.
`default_nettype none

module f2sb_out_stage #(
    parameter int ADDR_BITS = f2sb_pkg::ADDR_BITS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    f2sb_rsp_if.sink     i_res,
    f2sb_rsp_if.source   o_rsp
);
    import f2sb_pkg::*;

    logic                 r_valid;
    logic                 r_ack_out;
    logic                 r_rdata_valid;
    t_byte                r_rdata_out;
    logic                 r_bus_start;
    logic [ADDR_BITS-1:0] r_bus_addr;
    logic                 r_bus_read;
    logic                 r_bus_wdata_valid;
    t_byte                r_bus_wdata;

    assign i_res.ready = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res.ready) begin
            r_valid <= i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res.valid && i_res.ready) begin
            r_ack_out         <= i_res.ack_out;
            r_rdata_valid     <= i_res.rdata_valid;
            r_rdata_out       <= i_res.rdata_out;
            r_bus_start       <= i_res.bus_start;
            r_bus_addr        <= i_res.bus_addr;
            r_bus_read        <= i_res.bus_read;
            r_bus_wdata_valid <= i_res.bus_wdata_valid;
            r_bus_wdata       <= i_res.bus_wdata;
        end
    end

    assign o_rsp.valid           = r_valid;
    assign o_rsp.ack_out         = r_ack_out;
    assign o_rsp.rdata_valid     = r_rdata_valid;
    assign o_rsp.rdata_out       = r_rdata_out;
    assign o_rsp.bus_start       = r_bus_start;
    assign o_rsp.bus_addr        = r_bus_addr;
    assign o_rsp.bus_read        = r_bus_read;
    assign o_rsp.bus_wdata_valid = r_bus_wdata_valid;
    assign o_rsp.bus_wdata       = r_bus_wdata;

endmodule

`default_nettype wire

### rtl/core/fabric_to_system_bus_bridge_top.sv
// Top level of the fabric to system bus bridge: event register, bridge state, result register.
//
// The bridge takes one event word per handshake on i_req: cycle start, cycle end,
// address with write enable, write data, a system tick with its clock phase, or a tock.
// For every accepted event word it returns exactly one result word on o_rsp, carrying
// the acknowledge to the fabric master, returned read data, and the system bus launch
// (address, direction) and write data, each with its own valid flag.
// An accepted word is registered, decoded against the bridge state in one short
// combinational pass, and the result lands in an output register: the result appears
// on o_rsp once the word moves from the event register into the result register, and one
// word can be accepted in every cycle while the receiver is not stalled. The ready
// path runs from o_rsp.ready back to i_req.ready past the two register stages, so a
// stalled receiver fills the result register first, then the event register, and only
// then is i_req.ready dropped. Nothing is lost or repeated while stalled; the bridge
// state advances only when a word moves into the result register.
// Reset (i_rst_n low, synchronous) empties both stages and returns the bridge to the
// idle phase with no pending cycle, no pending write data, cleared latches and
// cleared tock flags.
`default_nettype none

module fabric_to_system_bus_bridge_top #(
    parameter int ADDR_BITS = f2sb_pkg::ADDR_BITS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    f2sb_req_if.sink     i_req,
    f2sb_rsp_if.source   o_rsp
);
    import f2sb_pkg::*;

    // Result word between the decode pass and the output register.
    f2sb_rsp_if #(.ADDR_BITS(ADDR_BITS)) res_mid ();

    f2sb_core #(.ADDR_BITS(ADDR_BITS)) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_res   (res_mid.source)
    );

    f2sb_out_stage #(.ADDR_BITS(ADDR_BITS)) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res_mid.sink),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire

### rtl/core/f2sb_checker.sv
// Port-level checks on the bridge result channel, bound to the top level.
`default_nettype none

module f2sb_checker #(
    parameter int ADDR_BITS = f2sb_pkg::ADDR_BITS_DEF
) (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           i_out_valid,
    input wire                           i_out_ready,
    input wire                           i_ack_out,
    input wire                           i_rdata_valid,
    input wire [f2sb_pkg::DATA_W-1:0]    i_rdata_out,
    input wire                           i_bus_start,
    input wire [ADDR_BITS-1:0]           i_bus_addr,
    input wire                           i_bus_read,
    input wire                           i_bus_wdata_valid,
    input wire [f2sb_pkg::DATA_W-1:0]    i_bus_wdata
);
    import f2sb_pkg::*;

    // A result word waiting on a stalled receiver is not withdrawn.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    // An acknowledge always comes with read data or with write data on the bus.
    a_ack_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_ack_out |-> i_rdata_valid || i_bus_wdata_valid)
        else $error("acknowledge without data");

    // Read data return and a read launch never share a word, and data fields are
    // zero when their flags are low.
    a_read_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_rdata_valid |-> !i_bus_start && !i_bus_wdata_valid)
        else $error("read return mixed with launch or write data");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_bus_start |->
            i_bus_addr == '0 && !i_bus_read
            && (i_rdata_valid || i_rdata_out == '0)
            && (i_bus_wdata_valid || i_bus_wdata == '0))
        else $error("data field set without its flag");

    // Write data at launch only accompanies a write launch.
    a_launch_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_bus_start && i_bus_wdata_valid |-> !i_bus_read && i_ack_out)
        else $error("write data on a read launch");

endmodule

bind fabric_to_system_bus_bridge_top f2sb_checker #(.ADDR_BITS(ADDR_BITS)) u_f2sb_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_rsp.valid),
    .i_out_ready       (o_rsp.ready),
    .i_ack_out         (o_rsp.ack_out),
    .i_rdata_valid     (o_rsp.rdata_valid),
    .i_rdata_out       (o_rsp.rdata_out),
    .i_bus_start       (o_rsp.bus_start),
    .i_bus_addr        (o_rsp.bus_addr),
    .i_bus_read        (o_rsp.bus_read),
    .i_bus_wdata_valid (o_rsp.bus_wdata_valid),
    .i_bus_wdata       (o_rsp.bus_wdata)
);

`default_nettype wire
